FILE: design/ray_slit_plate_intersect_assert.svh
// ----------------------------------------------------------------------------
// ray_slit_plate_intersect_assert.svh
// assertion macros used by the slit plate intersection design
// ----------------------------------------------------------------------------
`ifndef RAY_SLIT_PLATE_INTERSECT_ASSERT_SVH
`define RAY_SLIT_PLATE_INTERSECT_ASSERT_SVH

// same-cycle implication
`define RSPI_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("rspi assertion failed");

// next-cycle implication
`define RSPI_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("rspi assertion failed");

`endif

FILE: design/rspi_pkg.sv
// ----------------------------------------------------------------------------
// rspi_pkg
// types and constants of the slit plate intersection pipeline
// ----------------------------------------------------------------------------
package rspi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int CFG_W     = 31;
  localparam int CNT_W     = 10;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = 2 * WORD_BITS;
  localparam int SUM_W     = WORD_BITS + 3;
  localparam int SPAN_W    = CNT_W + CFG_W;
  localparam int U_W       = SPAN_W + 2;
  localparam int D2_W      = SPAN_W + 3;
  localparam int DIV_STEPS = 4;

  localparam logic [WORD_BITS-1:0] WSIGN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [WORD_BITS-1:0] WMAXU = ~WSIGN;
  localparam logic [WORD_BITS:0]   MUL_CAP = {1'b1, {WORD_BITS{1'b0}}};
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'($signed({1'b0, WMAXU[WORD_BITS-2:0]}));
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'($signed(WSIGN));

  localparam logic [CFG_W-1:0] RST_HALF_W = CFG_W'(65536);
  localparam logic [CFG_W-1:0] RST_HALF_H = CFG_W'(65536);
  localparam logic [CFG_W-1:0] RST_SLOT_W = CFG_W'(6554);
  localparam logic [CNT_W-1:0] RST_COUNT  = CNT_W'(1);
  localparam logic [CFG_W-1:0] RST_PITCH  = CFG_W'(13107);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALF_W = 3'd0,
    CFG_HALF_H = 3'd1,
    CFG_SLOT_W = 3'd2,
    CFG_COUNT  = 3'd3,
    CFG_PITCH  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] half_w;
    logic [CFG_W-1:0] half_h;
    logic [CFG_W-1:0] slot_w;
    logic [CNT_W-1:0] count;
    logic [CFG_W-1:0] pitch;
  } cfg_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] ox;
    logic signed [WORD_BITS-1:0] oy;
    logic [WORD_BITS-1:0]        dxm;
    logic [WORD_BITS-1:0]        dym;
    logic                        dxs;
    logic                        dys;
    logic signed [WORD_BITS-1:0] tlo;
    logic signed [WORD_BITS-1:0] thi;
    logic                        neg;
    logic                        dzero;
    logic                        front;
  } ray_side_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] ox;
    logic signed [WORD_BITS-1:0] oy;
    logic [WORD_BITS-1:0]        dxm;
    logic [WORD_BITS-1:0]        dym;
    logic                        dxs;
    logic                        dys;
    logic [WORD_BITS-1:0]        tmag;
    logic                        tneg;
    logic signed [WORD_BITS-1:0] t;
    logic                        miss;
    logic                        front;
  } proj_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] t;
    logic signed [WORD_BITS-1:0] x;
    logic signed [WORD_BITS-1:0] y;
    logic                        miss;
    logic                        front;
  } pt_t;

  typedef struct packed {
    pt_t               p;
    logic [SPAN_W-1:0] span;
    logic              use_div;
  } slit_side_t;

  typedef struct packed {
    logic                        is_hit;
    logic signed [WORD_BITS-1:0] t;
    logic signed [WORD_BITS-1:0] x;
    logic signed [WORD_BITS-1:0] y;
    logic                        front;
  } res_t;

endpackage

FILE: design/rspi_in_if.sv
// ----------------------------------------------------------------------------
// rspi_in_if
// ray beat channel: origin, direction and t window
// ----------------------------------------------------------------------------
interface rspi_in_if;
  logic valid;
  logic ready;
  logic signed [rspi_pkg::WORD_BITS-1:0] origin_x;
  logic signed [rspi_pkg::WORD_BITS-1:0] origin_y;
  logic signed [rspi_pkg::WORD_BITS-1:0] origin_z;
  logic signed [rspi_pkg::WORD_BITS-1:0] dir_x;
  logic signed [rspi_pkg::WORD_BITS-1:0] dir_y;
  logic signed [rspi_pkg::WORD_BITS-1:0] dir_z;
  logic signed [rspi_pkg::WORD_BITS-1:0] t_lower;
  logic signed [rspi_pkg::WORD_BITS-1:0] t_upper;

  modport source (
    output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_lower, t_upper,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_lower, t_upper,
    output ready
  );
endinterface

FILE: design/rspi_out_if.sv
// ----------------------------------------------------------------------------
// rspi_out_if
// hit result beat channel
// ----------------------------------------------------------------------------
interface rspi_out_if;
  logic valid;
  logic ready;
  logic is_hit;
  logic signed [rspi_pkg::WORD_BITS-1:0] hit_t;
  logic signed [rspi_pkg::WORD_BITS-1:0] hit_x;
  logic signed [rspi_pkg::WORD_BITS-1:0] hit_y;
  logic front_side;

  modport source (output valid, is_hit, hit_t, hit_x, hit_y, front_side, input ready);
  modport sink (input valid, is_hit, hit_t, hit_x, hit_y, front_side, output ready);
endinterface

FILE: design/ray_slit_plate_intersect.sv
// ----------------------------------------------------------------------------
// ray_slit_plate_intersect
// ray against slitted rectangular plate in its local frame, fixed point
//
//   channel  | dir | beat contents
//   ---------+-----+----------------------------------------------------
//   in_ch    | in  | origin xyz, direction xyz, t window
//   out_ch   | out | hit flag, t, local x and y, front face flag
//   cfg_*    | in  | register write: index and data, no read-back
//
// one ray per cycle unless out_ch stalls; the 32-bit t quotient takes eight
// divider stages and the 10-bit slit index three more at four bits a stage
// reset clears all stage valid bits and loads the register defaults
// a result held on out_ch with ready low freezes the whole pipeline
// ----------------------------------------------------------------------------
`include "ray_slit_plate_intersect_assert.svh"

module ray_slit_plate_intersect (
  input  logic                              clk,
  input  logic                              rst_n,
  rspi_in_if.sink                           in_ch,
  rspi_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [rspi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rspi_pkg::CFG_W-1:0]        cfg_data
);

  localparam int W    = rspi_pkg::WORD_BITS;
  localparam int FRAC = rspi_pkg::FRAC_BITS;
  localparam int SIDE_W = $bits(rspi_pkg::ray_side_t);

  rspi_pkg::cfg_t        cfg_r;
  logic                  en;

  logic                  s0_v_r;
  logic [W-1:0]          s0_un_r;
  logic [W-1:0]          s0_ud_r;
  rspi_pkg::ray_side_t   s0_r;
  rspi_pkg::ray_side_t   s0_nxt;

  logic                  dv_v;
  logic [W-1:0]          dv_q;
  logic                  dv_ovf;
  logic [SIDE_W-1:0]     dv_side_raw;
  rspi_pkg::ray_side_t   dv_side;

  logic [W-1:0]          qc;
  logic [W-1:0]          tmag;
  logic signed [W-1:0]   tval;
  logic                  a_v_r;
  rspi_pkg::proj_in_t    a_r;
  rspi_pkg::proj_in_t    a_nxt;

  logic                  pj_v;
  rspi_pkg::pt_t         pj_data;
  logic                  sl_v;
  rspi_pkg::res_t        sl_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_w <= rspi_pkg::RST_HALF_W;
      cfg_r.half_h <= rspi_pkg::RST_HALF_H;
      cfg_r.slot_w <= rspi_pkg::RST_SLOT_W;
      cfg_r.count  <= rspi_pkg::RST_COUNT;
      cfg_r.pitch  <= rspi_pkg::RST_PITCH;
    end else if (cfg_we) begin
      case (rspi_pkg::cfg_idx_t'(cfg_index))
        rspi_pkg::CFG_HALF_W: cfg_r.half_w <= cfg_data;
        rspi_pkg::CFG_HALF_H: cfg_r.half_h <= cfg_data;
        rspi_pkg::CFG_SLOT_W: cfg_r.slot_w <= cfg_data;
        rspi_pkg::CFG_COUNT:  cfg_r.count  <= cfg_data[rspi_pkg::CNT_W-1:0];
        rspi_pkg::CFG_PITCH:  cfg_r.pitch  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en          = !sl_v || out_ch.ready;
  assign in_ch.ready = en;

  // input stage: magnitudes and signs, t = -oz / dz
  always_comb begin
    s0_nxt.ox    = in_ch.origin_x;
    s0_nxt.oy    = in_ch.origin_y;
    s0_nxt.dxm   = in_ch.dir_x[W-1] ? W'(-in_ch.dir_x) : W'(in_ch.dir_x);
    s0_nxt.dym   = in_ch.dir_y[W-1] ? W'(-in_ch.dir_y) : W'(in_ch.dir_y);
    s0_nxt.dxs   = in_ch.dir_x[W-1];
    s0_nxt.dys   = in_ch.dir_y[W-1];
    s0_nxt.tlo   = in_ch.t_lower;
    s0_nxt.thi   = in_ch.t_upper;
    s0_nxt.neg   = (!in_ch.origin_z[W-1] && (in_ch.origin_z != '0)) ^ in_ch.dir_z[W-1];
    s0_nxt.dzero = (in_ch.dir_z == '0);
    s0_nxt.front = in_ch.dir_z[W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      a_v_r  <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_ch.valid;
      a_v_r  <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_un_r <= in_ch.origin_z[W-1] ? W'(-in_ch.origin_z) : W'(in_ch.origin_z);
      s0_ud_r <= in_ch.dir_z[W-1] ? W'(-in_ch.dir_z) : W'(in_ch.dir_z);
      s0_r    <= s0_nxt;
    end
  end

  rspi_udiv #(
    .N_W    (W + FRAC),
    .D_W    (W),
    .Q_W    (W),
    .SIDE_W (SIDE_W)
  ) u_tdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s0_v_r),
    .num       ({s0_un_r, {FRAC{1'b0}}}),
    .den       (s0_ud_r),
    .side_in   (s0_r),
    .out_valid (dv_v),
    .quot      (dv_q),
    .ovf       (dv_ovf),
    .side_out  (dv_side_raw)
  );

  assign dv_side = rspi_pkg::ray_side_t'(dv_side_raw);

  // saturate t, apply sign, window test, miss on zero dz
  always_comb begin
    qc = (dv_ovf || dv_q > rspi_pkg::WSIGN) ? rspi_pkg::WSIGN : dv_q;
    if (dv_side.neg) begin
      tmag = qc;
    end else begin
      tmag = (qc == rspi_pkg::WSIGN) ? rspi_pkg::WMAXU : qc;
    end
    tval       = dv_side.neg ? -$signed(tmag) : $signed(tmag);
    a_nxt.ox   = dv_side.ox;
    a_nxt.oy   = dv_side.oy;
    a_nxt.dxm  = dv_side.dxm;
    a_nxt.dym  = dv_side.dym;
    a_nxt.dxs  = dv_side.dxs;
    a_nxt.dys  = dv_side.dys;
    a_nxt.tmag = tmag;
    a_nxt.tneg = dv_side.neg;
    a_nxt.t    = tval;
    a_nxt.miss = dv_side.dzero || (tval < dv_side.tlo) || (tval > dv_side.thi);
    a_nxt.front = dv_side.front;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= a_nxt;
    end
  end

  rspi_proj u_proj (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (a_v_r),
    .in_data   (a_r),
    .out_valid (pj_v),
    .out_data  (pj_data)
  );

  rspi_slit u_slit (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .cfg       (cfg_r),
    .in_valid  (pj_v),
    .in_data   (pj_data),
    .out_valid (sl_v),
    .out_data  (sl_data)
  );

  assign out_ch.valid      = sl_v;
  assign out_ch.is_hit     = sl_data.is_hit;
  assign out_ch.hit_t      = sl_data.t;
  assign out_ch.hit_x      = sl_data.x;
  assign out_ch.hit_y      = sl_data.y;
  assign out_ch.front_side = sl_data.front;

  `RSPI_ASSERT_IMP(a_miss_zero, clk, rst_n, out_ch.valid && !out_ch.is_hit, (out_ch.hit_t == '0) && (out_ch.hit_x == '0) && (out_ch.hit_y == '0) && !out_ch.front_side)
  `RSPI_ASSERT_NXT(a_stall_hold, clk, rst_n, !en, $stable({s0_v_r, dv_v, a_v_r, pj_v, sl_v}))
  `RSPI_ASSERT_NXT(a_accept_enters, clk, rst_n, in_ch.valid && in_ch.ready, s0_v_r)

endmodule

FILE: design/rspi_udiv.sv
// ----------------------------------------------------------------------------
// rspi_udiv
// pipelined restoring divider, DIV_STEPS quotient bits per stage, with overflow
// flag for quotients wider than Q_W bits and a sideband carried alongside
// ----------------------------------------------------------------------------
module rspi_udiv #(
  parameter int N_W    = 48,
  parameter int D_W    = 32,
  parameter int Q_W    = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [N_W-1:0]    num,
  input  logic [D_W-1:0]    den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [Q_W-1:0]    quot,
  output logic              ovf,
  output logic [SIDE_W-1:0] side_out
);

  localparam int STEPS = rspi_pkg::DIV_STEPS;
  localparam int NS    = (Q_W + STEPS - 1) / STEPS;

  logic              v_r  [NS+1];
  logic [D_W-1:0]    r_r  [NS+1];
  logic [Q_W-1:0]    q_r  [NS+1];
  logic [Q_W-1:0]    lb_r [NS+1];
  logic [D_W-1:0]    d_r  [NS+1];
  logic              o_r  [NS+1];
  logic [SIDE_W-1:0] s_r  [NS+1];
  logic              ovf_nxt;

  assign ovf_nxt = N_W'(num[N_W-1:Q_W]) >= N_W'(den);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]  <= ovf_nxt ? '0 : D_W'(num[N_W-1:Q_W]);
      q_r[0]  <= '0;
      lb_r[0] <= num[Q_W-1:0];
      d_r[0]  <= den;
      o_r[0]  <= ovf_nxt;
      s_r[0]  <= side_in;
    end
  end

  for (genvar s = 1; s <= NS; s++) begin : g_st
    logic [D_W-1:0] r_nxt;
    logic [Q_W-1:0] q_nxt;
    logic [Q_W-1:0] lb_nxt;

    always_comb begin : c_step
      logic [D_W:0] acc;
      acc    = '0;
      r_nxt  = r_r[s-1];
      q_nxt  = q_r[s-1];
      lb_nxt = lb_r[s-1];
      for (int i = 0; i < STEPS; i++) begin
        if ((s - 1) * STEPS + i < Q_W) begin
          acc    = {r_nxt, lb_nxt[Q_W-1]};
          lb_nxt = lb_nxt << 1;
          if (acc >= {1'b0, d_r[s-1]}) begin
            acc   = acc - {1'b0, d_r[s-1]};
            q_nxt = {q_nxt[Q_W-2:0], 1'b1};
          end else begin
            q_nxt = {q_nxt[Q_W-2:0], 1'b0};
          end
          r_nxt = acc[D_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[s]  <= r_nxt;
        q_r[s]  <= q_nxt;
        lb_r[s] <= lb_nxt;
        d_r[s]  <= d_r[s-1];
        o_r[s]  <= o_r[s-1];
        s_r[s]  <= s_r[s-1];
      end
    end
  end

  assign out_valid = v_r[NS];
  assign quot      = q_r[NS];
  assign ovf       = o_r[NS];
  assign side_out  = s_r[NS];

endmodule

FILE: design/rspi_proj.sv
// ----------------------------------------------------------------------------
// rspi_proj
// hit point projection: t times direction, scaled, added to origin, saturated
// ----------------------------------------------------------------------------
module rspi_proj (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  rspi_pkg::proj_in_t  in_data,
  output logic                out_valid,
  output rspi_pkg::pt_t       out_data
);

  localparam int W    = rspi_pkg::WORD_BITS;
  localparam int FRAC = rspi_pkg::FRAC_BITS;
  localparam int PW   = rspi_pkg::PROD_W;
  localparam int SW   = rspi_pkg::SUM_W;

  function automatic logic signed [W-1:0] axis_sum(
    input logic [PW-1:0]       prod,
    input logic                neg,
    input logic signed [W-1:0] org
  );
    logic [PW-FRAC-1:0]     m;
    logic [W:0]             capv;
    logic signed [SW-1:0]   term;
    logic signed [SW-1:0]   sum;
    logic signed [W-1:0]    res;
    m    = prod[PW-1:FRAC];
    capv = (m > (PW-FRAC)'(rspi_pkg::MUL_CAP)) ? rspi_pkg::MUL_CAP : m[W:0];
    term = $signed(SW'(capv));
    if (neg) begin
      term = -term;
    end
    sum = SW'(org) + term;
    if (sum > rspi_pkg::SUM_MAX) begin
      res = rspi_pkg::SUM_MAX[W-1:0];
    end else if (sum < rspi_pkg::SUM_MIN) begin
      res = rspi_pkg::SUM_MIN[W-1:0];
    end else begin
      res = sum[W-1:0];
    end
    return res;
  endfunction

  logic                p1_v_r;
  logic [PW-1:0]       px_r;
  logic [PW-1:0]       py_r;
  logic                sx_r;
  logic                sy_r;
  rspi_pkg::pt_t       p1_r;
  logic                p2_v_r;
  rspi_pkg::pt_t       p2_r;
  rspi_pkg::pt_t       p2_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= in_valid;
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r       <= PW'(in_data.tmag) * PW'(in_data.dxm);
      py_r       <= PW'(in_data.tmag) * PW'(in_data.dym);
      sx_r       <= in_data.tneg ^ in_data.dxs;
      sy_r       <= in_data.tneg ^ in_data.dys;
      p1_r.t     <= in_data.t;
      p1_r.x     <= in_data.ox;
      p1_r.y     <= in_data.oy;
      p1_r.miss  <= in_data.miss;
      p1_r.front <= in_data.front;
    end
  end

  always_comb begin
    p2_nxt   = p1_r;
    p2_nxt.x = axis_sum(px_r, sx_r, p1_r.x);
    p2_nxt.y = axis_sum(py_r, sy_r, p1_r.y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_r <= p2_nxt;
    end
  end

  assign out_valid = p2_v_r;
  assign out_data  = p2_r;

endmodule

FILE: design/rspi_slit.sv
// ----------------------------------------------------------------------------
// rspi_slit
// plate bounds and nearest slit test, result register of the pipeline
// ----------------------------------------------------------------------------
module rspi_slit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  rspi_pkg::cfg_t      cfg,
  input  logic                in_valid,
  input  rspi_pkg::pt_t       in_data,
  output logic                out_valid,
  output rspi_pkg::res_t      out_data
);

  localparam int W    = rspi_pkg::WORD_BITS;
  localparam int CW   = rspi_pkg::CFG_W;
  localparam int NW   = rspi_pkg::CNT_W;
  localparam int SPW  = rspi_pkg::SPAN_W;
  localparam int UW   = rspi_pkg::U_W;
  localparam int D2W  = rspi_pkg::D2_W;
  localparam int SIDE_W = $bits(rspi_pkg::slit_side_t);

  logic [NW-1:0]         cm1;
  logic [W-1:0]          ax;
  logic [W-1:0]          ay;
  logic                  d_v_r;
  rspi_pkg::pt_t         d_r;
  rspi_pkg::pt_t         d_nxt;
  logic [SPW-1:0]        d_span_r;

  logic signed [UW-1:0]  x2;
  logic signed [UW-1:0]  spn;
  logic signed [UW-1:0]  u_val;
  logic signed [UW-1:0]  nm;
  rspi_pkg::slit_side_t  e_side;

  logic                  dv_v;
  logic [NW-1:0]         dv_q;
  logic                  dv_ovf;
  logic [SIDE_W-1:0]     dv_side_raw;
  rspi_pkg::slit_side_t  dv_side;

  logic [NW-1:0]         k_val;
  logic                  f_v_r;
  rspi_pkg::slit_side_t  f_r;
  logic [SPW-1:0]        f_kp_r;

  logic signed [D2W-1:0] d2;
  logic [D2W-1:0]        diff;
  logic                  open_slit;
  logic                  g_v_r;
  rspi_pkg::res_t        g_r;
  rspi_pkg::res_t        g_nxt;

  assign cm1 = cfg.count - NW'(1);

  // bounds of the plate
  always_comb begin
    ax         = in_data.x[W-1] ? W'(-in_data.x) : W'(in_data.x);
    ay         = in_data.y[W-1] ? W'(-in_data.y) : W'(in_data.y);
    d_nxt      = in_data;
    d_nxt.miss = in_data.miss || (ax > W'(cfg.half_w)) || (ay > W'(cfg.half_h));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
      f_v_r <= 1'b0;
      g_v_r <= 1'b0;
    end else if (en) begin
      d_v_r <= in_valid;
      f_v_r <= dv_v;
      g_v_r <= f_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r      <= d_nxt;
      d_span_r <= SPW'(cm1) * SPW'(cfg.pitch);
    end
  end

  // doubled units: u = 2x + span, index = (u + pitch) / (2 pitch)
  always_comb begin
    x2             = UW'(d_r.x) <<< 1;
    spn            = $signed(UW'(d_span_r));
    u_val          = x2 + spn;
    nm             = x2 + spn + $signed(UW'(cfg.pitch));
    e_side.p       = d_r;
    e_side.span    = d_span_r;
    e_side.use_div = (cfg.count > NW'(1)) && (cfg.pitch != '0) &&
                     (u_val > $signed(UW'(0)));
  end

  rspi_udiv #(
    .N_W    (UW),
    .D_W    (CW + 1),
    .Q_W    (NW),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d_v_r),
    .num       (nm),
    .den       ({cfg.pitch, 1'b0}),
    .side_in   (e_side),
    .out_valid (dv_v),
    .quot      (dv_q),
    .ovf       (dv_ovf),
    .side_out  (dv_side_raw)
  );

  assign dv_side = rspi_pkg::slit_side_t'(dv_side_raw);

  // slit index: zero without the divide, else clamped to the last slit
  always_comb begin
    if (!dv_side.use_div) begin
      k_val = '0;
    end else if (dv_ovf || dv_q > cm1) begin
      k_val = cm1;
    end else begin
      k_val = dv_q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_r    <= dv_side;
      f_kp_r <= SPW'(k_val) * SPW'(cfg.pitch);
    end
  end

  // distance from the chosen centre, doubled
  always_comb begin
    d2 = (D2W'(f_r.p.x) <<< 1) - ($signed(D2W'(f_kp_r)) <<< 1) + $signed(D2W'(f_r.span));
    diff      = d2[D2W-1] ? D2W'(-d2) : D2W'(d2);
    open_slit = (cfg.count != '0) && (diff < D2W'(cfg.slot_w));
    if (f_r.p.miss || open_slit) begin
      g_nxt = '0;
    end else begin
      g_nxt.is_hit = 1'b1;
      g_nxt.t      = f_r.p.t;
      g_nxt.x      = f_r.p.x;
      g_nxt.y      = f_r.p.y;
      g_nxt.front  = f_r.p.front;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_r <= g_nxt;
    end
  end

  assign out_valid = g_v_r;
  assign out_data  = g_r;

endmodule

FILE: sim/rspi_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rspi_tb_if
// note: the channel interfaces are compiled from the design folder; this
// file only holds helper types shared by the bench
// ----------------------------------------------------------------------------
package rspi_tb_pkg;

  typedef struct packed {
    logic signed [rspi_pkg::WORD_BITS-1:0] ox;
    logic signed [rspi_pkg::WORD_BITS-1:0] oy;
    logic signed [rspi_pkg::WORD_BITS-1:0] oz;
    logic signed [rspi_pkg::WORD_BITS-1:0] dx;
    logic signed [rspi_pkg::WORD_BITS-1:0] dy;
    logic signed [rspi_pkg::WORD_BITS-1:0] dz;
    logic signed [rspi_pkg::WORD_BITS-1:0] tlo;
    logic signed [rspi_pkg::WORD_BITS-1:0] thi;
  } ray_t;
endpackage

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for ray_slit_plate_intersect: directed rays from a
// stimulus table, then random rays through several plate settings, each
// result compared field by field with a behavioural hit predictor
// ----------------------------------------------------------------------------
module tb;

  localparam logic signed [63:0] WMAX = 64'sd2147483647;
  localparam logic signed [63:0] WMIN = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [rspi_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rspi_pkg::CFG_W-1:0] cfg_data = '0;

  rspi_in_if  in_ch();
  rspi_out_if out_ch();

  ray_slit_plate_intersect dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rspi_pkg::cfg_t plate;
  rspi_pkg::res_t hit_queue[$];
  int   n_fail = 0;
  int   n_rays = 0;
  int   n_hits = 0;
  int   n_res  = 0;
  bit   hold_off = 1'b0;
  bit   stim_done = 1'b0;

  function automatic logic signed [63:0] clip(input logic signed [63:0] v);
    if (v > WMAX) return WMAX;
    if (v < WMIN) return WMIN;
    return v;
  endfunction

  function automatic logic signed [63:0] t_quot(input logic signed [63:0] n,
                                                input logic signed [63:0] d);
    logic [63:0] un, ud, q, r;
    bit neg;
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    q = un / ud;
    r = un % ud;
    neg = (n < 0) != (d < 0);
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    else begin
      for (int i = 0; i < rspi_pkg::FRAC_BITS; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= ud) begin
          q[0] = 1'b1;
          r = r - ud;
        end
        if (q > 64'h8000_0000) begin
          q = 64'h8000_0000;
          break;
        end
      end
    end
    return clip(neg ? -$signed(q) : $signed(q));
  endfunction

  function automatic logic signed [63:0] t_scale(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [127:0] p;
    logic [127:0] m;
    p = (a < 0 ? -a : a) * (b < 0 ? -b : b);
    m = p >> rspi_pkg::FRAC_BITS;
    if (m > 128'h1_0000_0000) m = 128'h1_0000_0000;
    return ((a < 0) != (b < 0)) ? -$signed(m[63:0]) : $signed(m[63:0]);
  endfunction

  function automatic bit in_slit(input logic signed [63:0] x);
    logic signed [63:0] pitch, span, u, k, n2, diff;
    pitch = plate.pitch;
    if (plate.count == 0) return 1'b0;
    span = (plate.count - 1) * pitch;
    k = 0;
    if (plate.count > 1 && pitch != 0) begin
      u = 2 * x + span;
      if (u > 0) k = (u + pitch) / (2 * pitch);
      if (k > plate.count - 1) k = plate.count - 1;
    end
    n2 = 2 * k * pitch - span;
    diff = 2 * x - n2;
    if (diff < 0) diff = -diff;
    return diff < $signed({33'd0, plate.slot_w});
  endfunction

  function automatic rspi_pkg::res_t plate_hit(input rspi_tb_pkg::ray_t r);
    rspi_pkg::res_t o;
    logic signed [63:0] t, x, y;
    o = '0;
    if (r.dz == 0) return o;
    t = t_quot(-64'(r.oz), 64'(r.dz));
    if (t < r.tlo || t > r.thi) return o;
    x = clip(64'(r.ox) + t_scale(t, 64'(r.dx)));
    y = clip(64'(r.oy) + t_scale(t, 64'(r.dy)));
    if ((x < 0 ? -x : x) > plate.half_w || (y < 0 ? -y : y) > plate.half_h) return o;
    if (in_slit(x)) return o;
    o.is_hit = 1'b1;
    o.t = t[31:0];
    o.x = x[31:0];
    o.y = y[31:0];
    o.front = r.dz < 0;
    return o;
  endfunction

  function automatic void note_expected(input rspi_pkg::res_t v);
    hit_queue = {hit_queue, v};
  endfunction

  task automatic write_reg(input rspi_pkg::cfg_idx_t idx,
                           input logic [rspi_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      rspi_pkg::CFG_HALF_W: plate.half_w = val;
      rspi_pkg::CFG_HALF_H: plate.half_h = val;
      rspi_pkg::CFG_SLOT_W: plate.slot_w = val;
      rspi_pkg::CFG_COUNT:  plate.count = val[rspi_pkg::CNT_W-1:0];
      rspi_pkg::CFG_PITCH:  plate.pitch = val;
      default: ;
    endcase
  endtask

  task automatic send_ray(input rspi_tb_pkg::ray_t r, input bit pace);
    int gap;
    gap = (pace && $urandom_range(3) != 0) ? $urandom_range(19) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.origin_x, in_ch.origin_y, in_ch.origin_z, in_ch.dir_x, in_ch.dir_y,
     in_ch.dir_z, in_ch.t_lower, in_ch.t_upper} <= r;
    do @(posedge clk); while (!in_ch.ready);
    note_expected(plate_hit(r));
    n_rays++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (hit_queue.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h7FFF_FFFF - $urandom_range(3);
      2: return 32'h8000_0000 + $urandom_range(3);
      default: return $signed($urandom_range(262144)) - 131072;
    endcase
  endfunction

  // mostly rays aimed at the plate with a wide window
  function automatic rspi_tb_pkg::ray_t rnd_ray();
    rspi_tb_pkg::ray_t r;
    r = {rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(),
         rnd_word(), rnd_word()};
    if ($urandom_range(9) < 7) begin
      r.oz = $signed($urandom_range(131072)) - 65536;
      r.dz = ($urandom_range(1) ? 32'sd65536 : -32'sd65536) +
             ($signed($urandom_range(2048)) - 1024);
      r.dx = $signed($urandom_range(65536)) - 32768;
      r.dy = $signed($urandom_range(65536)) - 32768;
      r.ox = $signed($urandom_range(196608)) - 98304;
      r.oy = $signed($urandom_range(196608)) - 98304;
      r.tlo = $urandom_range(3) == 0 ? $signed(rnd_word()) : -32'sd262144;
      r.thi = $urandom_range(3) == 0 ? $signed(rnd_word()) : 32'sd262144;
    end
    return r;
  endfunction

  rspi_tb_pkg::ray_t tbl_ray[16];
  rspi_pkg::res_t    tbl_res[16];
  bit                tbl_fix[16];

  initial begin
    // ox oy oz dx dy dz tlo thi
    tbl_ray[0]  = '{0, 0, 65536, 0, 0, 0, -65536, 65536};
    tbl_ray[1]  = '{0, 0, 65536, 0, 0, -65536, 65536, 0};
    tbl_ray[2]  = '{16384, 0, 65536, 0, 0, -65536, -131072, 131072};
    tbl_ray[3]  = '{0, 0, 65536, 0, 0, -65536, -131072, 131072};
    tbl_ray[4]  = '{3277, 0, -65536, 0, 0, 65536, -131072, 131072};
    tbl_ray[5]  = '{65536, 65536, 0, 0, 0, 65536, 0, 0};
    tbl_ray[6]  = '{65537, 0, 0, 0, 0, 65536, 0, 0};
    tbl_ray[7]  = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 1, 32'h8000_0000, 32'h7FFF_FFFF};
    tbl_ray[8]  = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
    tbl_ray[9]  = '{0, 0, 32'h8000_0000, 65536, 65536, -1, 32'h8000_0000, 32'h7FFF_FFFF};
    tbl_ray[10] = '{-16384, 100, 65536, 32768, -32768, 65536, -131072, 131072};
    tbl_ray[11] = '{-1, -1, -1, -1, -1, -1, -1, -1};
    tbl_ray[12] = '{0, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0};
    tbl_ray[13] = '{-65536, -65536, 0, 0, 0, -1, 0, 0};
    tbl_ray[14] = '{3276, 0, 0, 0, 0, 65536, 0, 0};
    tbl_ray[15] = '{-3277, 5, 0, 0, 0, -65536, 0, 0};
    foreach (tbl_fix[i]) tbl_fix[i] = 1'b0;
    tbl_fix[0] = 1'b1; tbl_res[0] = '0;
    tbl_fix[1] = 1'b1; tbl_res[1] = '0;
    tbl_fix[3] = 1'b1; tbl_res[3] = '0;
    tbl_fix[5] = 1'b1; tbl_res[5] = '{1'b1, 0, 65536, 65536, 1'b0};
    tbl_fix[6] = 1'b1; tbl_res[6] = '0;
    tbl_fix[14] = 1'b1; tbl_res[14] = '0;
    tbl_fix[15] = 1'b1; tbl_res[15] = '{1'b1, 0, -3277, 5, 1'b1};
  end

  initial begin
    rspi_tb_pkg::ray_t r;
    logic [rspi_pkg::CFG_W-1:0] setting[5];
    in_ch.valid = 1'b0;
    {in_ch.origin_x, in_ch.origin_y, in_ch.origin_z, in_ch.dir_x, in_ch.dir_y,
     in_ch.dir_z, in_ch.t_lower, in_ch.t_upper} = '0;
    plate = '{rspi_pkg::RST_HALF_W, rspi_pkg::RST_HALF_H, rspi_pkg::RST_SLOT_W,
              rspi_pkg::RST_COUNT, rspi_pkg::RST_PITCH};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < 16; i++) begin
      if (tbl_fix[i] && plate_hit(tbl_ray[i]) !== tbl_res[i]) begin
        $error("table row %0d disagrees with predictor", i);
        n_fail++;
      end
      send_ray(tbl_ray[i], 1'b1);
    end
    drain();
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: setting = '{31'h7FFF_FFFF, 31'h7FFF_FFFF, 1, 10'd1023, 1};
        1: setting = '{1, 1, 31'h7FFF_FFFF, 10'd0, 31'h7FFF_FFFF};
        2: setting = '{131072, 65536, 4000, 10'd7, 16384};
        3: setting = '{65536, 131072, 0, 10'd4, 0};
        4: setting = '{98304, 98304, 6554, 10'd2, 0};
        5: setting = '{65536, 65536, 2000, 10'd1023, 128};
        default: setting = '{$urandom_range(200000, 1), $urandom_range(200000, 1),
                             $urandom_range(20000), $urandom_range(1023),
                             $urandom_range(40000)};
      endcase
      for (int i = 0; i < 5; i++) write_reg(rspi_pkg::cfg_idx_t'(i), setting[i]);
      cfg_we <= 1'b0;
      if (ph == 3) hold_off = 1'b1;
      for (int n = 0; n < 125; n++) begin
        r = rnd_ray();
        send_ray(r, ph != 4);
      end
      drain();
    end
    stim_done = 1'b1;
  end

  initial begin
    int wait_n;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (200) @(posedge clk);
      end
      wait_n = ($urandom_range(3) == 0) ? $urandom_range(19) : 0;
      if (wait_n != 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    rspi_pkg::res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_res++;
      if (hit_queue.size() == 0) begin
        $error("result beat with no ray outstanding");
        n_fail++;
      end else begin
        want = hit_queue.pop_front();
        if (want.is_hit) n_hits++;
        if (out_ch.is_hit !== want.is_hit) begin
          $error("is_hit expected %0d got %0d", want.is_hit, out_ch.is_hit); n_fail++;
        end
        if (out_ch.hit_t !== want.t) begin
          $error("hit_t expected %0d got %0d", want.t, out_ch.hit_t); n_fail++;
        end
        if (out_ch.hit_x !== want.x) begin
          $error("hit_x expected %0d got %0d", want.x, out_ch.hit_x); n_fail++;
        end
        if (out_ch.hit_y !== want.y) begin
          $error("hit_y expected %0d got %0d", want.y, out_ch.hit_y); n_fail++;
        end
        if (out_ch.front_side !== want.front) begin
          $error("front_side expected %0d got %0d", want.front, out_ch.front_side);
          n_fail++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    if (hit_queue.size() != 0) begin
      $error("%0d results never arrived", hit_queue.size());
      n_fail++;
    end
    $display("%0d rays sent over nine plate settings, %0d results, %0d hits",
             n_rays, n_res, n_hits);
    if (n_fail == 0) $display("** ray_slit_plate_intersect: PASSED **");
    else $display("** ray_slit_plate_intersect: FAILED **");
    $finish;
  end

  initial begin
    #3ms;
    $display("** ray_slit_plate_intersect: FAILED **");
    $finish;
  end
endmodule
